>>> rtl/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// shared widths, defaults and the step descriptor passed from the patch
// control unit to the output stage
// ----------------------------------------------------------------------------
package bdp_pkg;

  localparam int unsigned OLD_DEPTH_DEFAULT = 65536;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned OLD_SIZE_W = 17;
  localparam int unsigned NEW_SIZE_W = 32;
  localparam int unsigned NEWPOS_W   = 33;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PATCH = 1'b1;

  localparam logic CFG_OLD_SIZE = 1'b0;
  localparam logic CFG_NEW_SIZE = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               use_old;
    logic               status;
    logic               last;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
  } step_t;

endpackage

>>> rtl/binary_delta_patch_apply.sv
// ----------------------------------------------------------------------------
// binary_delta_patch_apply
// applies a binary delta patch stream to an old image held in on-chip ram
//
//   channel  dir  contents
//   s_axis   in   tdata: old_addr[15:0], data_byte[23:16]; tuser: mode
//   m_axis   out  tdata: new_byte[7:0], new_index[39:8]; tuser: status;
//                 tlast: last
//   cfg      in   cfg_index 0 old_size, 1 new_size; cfg_data
//
// one input transaction per cycle while the output is not stalled; a result
// is registered in the old image ram read stage and then in the output register
// reset clears the control state only; the old image ram keeps its contents
// a stalled output holds the read stage, then input tready drops
// ----------------------------------------------------------------------------
module binary_delta_patch_apply #(
  parameter int unsigned OLD_DEPTH = bdp_pkg::OLD_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // old_addr, data_byte
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // new_byte, new_index
  output logic                              m_axis_tuser,  // status
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bdp_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned AW = $clog2(OLD_DEPTH);
  localparam int unsigned BW = bdp_pkg::BYTE_W;

  logic [bdp_pkg::OLD_SIZE_W-1:0] old_size;
  logic [bdp_pkg::NEW_SIZE_W-1:0] new_size;

  logic [bdp_pkg::ADDR_W-1:0] old_addr;
  logic [BW-1:0]              data_byte;
  logic                       accept;
  logic                       advance;

  bdp_pkg::step_t step;
  bdp_pkg::step_t p1;
  logic           p1_valid;
  logic [AW-1:0]  rd_addr;
  logic [BW-1:0]  rd_data;
  logic           wr_en;

  logic [BW-1:0] mem [OLD_DEPTH];

  logic [BW-1:0]               out_byte;
  logic [bdp_pkg::INDEX_W-1:0] out_index;
  logic                        out_status;
  logic                        out_last;
  logic                        out_valid;

  assign old_addr  = s_axis_tdata[bdp_pkg::ADDR_W-1:0];
  assign data_byte = s_axis_tdata[bdp_pkg::ADDR_W +: BW];

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !p1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign wr_en = accept && (s_axis_tuser == bdp_pkg::MODE_LOAD) &&
                 (32'(old_addr) < 32'(OLD_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      old_size <= '0;
      new_size <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bdp_pkg::CFG_OLD_SIZE) begin
        old_size <= cfg_data[bdp_pkg::OLD_SIZE_W-1:0];
      end else begin
        new_size <= cfg_data[bdp_pkg::NEW_SIZE_W-1:0];
      end
    end
  end

  bdp_ctrl #(
    .OLD_DEPTH (OLD_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_axis_tuser),
    .data_byte (data_byte),
    .old_size  (old_size),
    .new_size  (new_size),
    .step      (step),
    .rd_addr   (rd_addr)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(old_addr)] <= data_byte;
    end
    if (accept && step.use_old) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept && step.valid) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.valid) begin
      p1 <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p1_valid) begin
      out_byte   <= p1.data + (p1.use_old ? rd_data : '0);
      out_index  <= p1.index;
      out_status <= p1.status;
      out_last   <= p1.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_byte};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

>>> rtl/bdp_ctrl.sv
// ----------------------------------------------------------------------------
// bdp_ctrl
// patch stream control: control word assembly, length checks, diff and
// extra run counting, old and new positions; issues one step per diff or
// extra byte, and an error step for a corrupt group
module bdp_ctrl #(
  parameter int unsigned OLD_DEPTH = bdp_pkg::OLD_DEPTH_DEFAULT,
  parameter int unsigned AW        = $clog2(OLD_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              mode,
  input  logic [bdp_pkg::BYTE_W-1:0]        data_byte,
  input  logic [bdp_pkg::OLD_SIZE_W-1:0]    old_size,
  input  logic [bdp_pkg::NEW_SIZE_W-1:0]    new_size,
  output bdp_pkg::step_t                    step,
  output logic [AW-1:0]                     rd_addr
);

  localparam logic [2:0] PH_CONTROL = 3'd0;
  localparam logic [2:0] PH_DIFF    = 3'd1;
  localparam logic [2:0] PH_EXTRA   = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_HALT    = 3'd4;

  localparam int unsigned WW = bdp_pkg::WORD_W;
  localparam int unsigned PW = bdp_pkg::NEWPOS_W;

  localparam logic [4:0] CNT_DIFF  = 5'd8;
  localparam logic [4:0] CNT_EXTRA = 5'd16;
  localparam logic [4:0] CNT_SEEK  = 5'd24;

  logic [2:0]    phase, phase_next;
  logic [4:0]    count, count_next;
  logic [WW-1:0] asm_word, asm_word_next;
  logic [WW-1:0] diff_rem, diff_rem_next;
  logic [WW-1:0] extra_rem, extra_rem_next;
  logic [WW-1:0] seek, seek_next;
  logic [PW-1:0] new_pos, new_pos_next;
  logic [WW-1:0] old_pos, old_pos_next;

  logic [WW-1:0] asm_shift;
  logic [WW-1:0] mag;
  logic [WW-1:0] value;
  logic [PW-1:0] new_size_ext;
  logic [PW-1:0] new_pos_inc;
  logic          pos_full;
  logic          inc_full;
  logic [PW-1:0] room;
  logic [PW:0]   run_sum;
  logic          bad;
  logic          in_range;
  logic [WW-1:0] old_add;
  logic          old_inc;

  assign new_size_ext = {1'b0, new_size};
  assign new_pos_inc  = new_pos + PW'(1);
  assign pos_full     = new_pos >= new_size_ext;
  assign inc_full     = new_pos_inc >= new_size_ext;
  assign room         = pos_full ? '0 : new_size_ext - new_pos;
  assign run_sum      = {1'b0, diff_rem[PW-1:0]} + {1'b0, extra_rem[PW-1:0]};

  assign asm_shift = {data_byte, asm_word[WW-1:8]};
  assign mag       = {1'b0, asm_shift[WW-2:0]};
  assign value     = asm_shift[WW-1] ? (WW'(0) - mag) : mag;

  assign bad = diff_rem[WW-1] || extra_rem[WW-1] ||
               (diff_rem[WW-1:PW] != '0) || (extra_rem[WW-1:PW] != '0) ||
               (diff_rem[PW-1:0] > room) || (run_sum > {1'b0, room});

  assign in_range = (old_pos[WW-1:bdp_pkg::OLD_SIZE_W] == '0) &&
                    (old_pos[bdp_pkg::OLD_SIZE_W-1:0] < old_size) &&
                    (old_pos < WW'(OLD_DEPTH));

  assign rd_addr = old_pos[AW-1:0];

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    asm_word_next  = asm_word;
    diff_rem_next  = diff_rem;
    extra_rem_next = extra_rem;
    seek_next      = seek;
    new_pos_next   = new_pos;
    old_add        = '0;
    old_inc        = 1'b0;
    step           = '0;
    if (accept && mode == bdp_pkg::MODE_PATCH) begin
      case (phase)
        PH_CONTROL: begin
          if (pos_full) begin
            phase_next = PH_DONE;
          end else begin
            asm_word_next = asm_shift;
            count_next    = count + 5'd1;
            if (count_next == CNT_DIFF) begin
              diff_rem_next = value;
            end else if (count_next == CNT_EXTRA) begin
              extra_rem_next = value;
            end else if (count_next == CNT_SEEK) begin
              seek_next  = value;
              count_next = '0;
              if (bad) begin
                step.valid  = 1'b1;
                step.status = 1'b1;
                step.index  = new_pos[bdp_pkg::INDEX_W-1:0];
                phase_next  = PH_HALT;
              end else if (diff_rem != '0) begin
                phase_next = PH_DIFF;
              end else if (extra_rem != '0) begin
                phase_next = PH_EXTRA;
              end else begin
                old_add    = value;
                phase_next = pos_full ? PH_DONE : PH_CONTROL;
              end
            end
          end
        end
        PH_DIFF: begin
          step.valid    = 1'b1;
          step.use_old  = in_range;
          step.data     = data_byte;
          step.index    = new_pos[bdp_pkg::INDEX_W-1:0];
          step.last     = new_pos_inc == new_size_ext;
          new_pos_next  = new_pos_inc;
          old_inc       = 1'b1;
          diff_rem_next = diff_rem - WW'(1);
          if (diff_rem == WW'(1)) begin
            if (extra_rem != '0) begin
              phase_next = PH_EXTRA;
            end else begin
              old_add    = seek;
              phase_next = inc_full ? PH_DONE : PH_CONTROL;
            end
          end
        end
        PH_EXTRA: begin
          step.valid     = 1'b1;
          step.data      = data_byte;
          step.index     = new_pos[bdp_pkg::INDEX_W-1:0];
          step.last      = new_pos_inc == new_size_ext;
          new_pos_next   = new_pos_inc;
          extra_rem_next = extra_rem - WW'(1);
          if (extra_rem == WW'(1)) begin
            old_add    = seek;
            phase_next = inc_full ? PH_DONE : PH_CONTROL;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    old_pos_next = old_pos + old_add + WW'(old_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CONTROL;
      count     <= '0;
      asm_word  <= '0;
      diff_rem  <= '0;
      extra_rem <= '0;
      seek      <= '0;
      new_pos   <= '0;
      old_pos   <= '0;
    end else begin
      phase     <= phase_next;
      count     <= count_next;
      asm_word  <= asm_word_next;
      diff_rem  <= diff_rem_next;
      extra_rem <= extra_rem_next;
      seek      <= seek_next;
      new_pos   <= new_pos_next;
      old_pos   <= old_pos_next;
    end
  end

endmodule

>>> tb/binary_delta_patch_apply_test.sv
// ----------------------------------------------------------------------------
// binary_delta_patch_apply_test
// self-checking bench for the delta patch applier. a scoreboard class keeps
// its own copy of the old image, the control group decoder and the output
// position, and predicts every new image byte and error result. stimulus is
// a few directed groups followed by random well-formed control groups under
// several store and image sizes, with stray image writes, mid-group size
// changes and one terminal case: a corrupt group or a completed image.
// ----------------------------------------------------------------------------
module binary_delta_patch_apply_test;

  localparam logic [63:0] MINUS_ZERO = {1'b1, 63'd0};

  localparam logic [2:0] ST_CONTROL = 3'd0;
  localparam logic [2:0] ST_DIFF    = 3'd1;
  localparam logic [2:0] ST_EXTRA   = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_HALT    = 3'd4;

  typedef struct {
    logic [7:0]  new_byte;
    logic [31:0] new_index;
    logic        status;
    logic        done_flag;
  } patch_out_t;

  class patch_book;
    logic [7:0]   img [65536];
    bit           written [65536];
    logic [16:0]  old_size = '0;
    logic [31:0]  new_size = '0;
    logic [2:0]   ph = ST_CONTROL;
    int           nctl = 0;
    logic [63:0]  shreg = '0;
    logic [63:0]  diff_left = '0;
    logic [63:0]  extra_left = '0;
    logic [63:0]  seek = '0;
    logic [32:0]  pos = '0;
    logic [63:0]  opos = '0;
    patch_out_t   pending [$];
    int           errors = 0;

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == bdp_pkg::CFG_OLD_SIZE) begin
        old_size = val[16:0];
      end else begin
        new_size = val;
      end
    endfunction

    function logic [63:0] old_limit();
      return (old_size > 17'd65536) ? 64'd65536 : 64'(old_size);
    endfunction

    function bit unloaded(output logic [15:0] a);
      a = opos[15:0];
      return ph == ST_DIFF && opos < old_limit() && !written[opos[15:0]];
    endfunction

    function logic [63:0] sm_value(logic [63:0] w);
      logic [63:0] mag;
      mag = {1'b0, w[62:0]};
      return w[63] ? -mag : mag;
    endfunction

    function void emit(logic [7:0] b);
      patch_out_t r;
      r.new_byte = b;
      r.new_index = pos[31:0];
      r.status = 1'b0;
      pos = pos + 33'd1;
      r.done_flag = (pos == {1'b0, new_size});
      pending.push_back(r);
    endfunction

    function void close_group();
      opos = opos + seek;
      ph = ({31'd0, pos} >= {32'd0, new_size}) ? ST_DONE : ST_CONTROL;
    endfunction

    function void note(logic m, logic [15:0] a, logic [7:0] b);
      logic [63:0] v;
      logic [63:0] room;
      logic [7:0]  val;
      patch_out_t  r;
      if (m == bdp_pkg::MODE_LOAD) begin
        img[a] = b;
        written[a] = 1'b1;
        return;
      end
      case (ph)
        ST_CONTROL: begin
          if ({31'd0, pos} >= {32'd0, new_size}) begin
            ph = ST_DONE;
            return;
          end
          shreg = {b, shreg[63:8]};
          nctl++;
          if (nctl % 8 != 0) return;
          v = sm_value(shreg);
          if (nctl == 8) begin
            diff_left = v;
            return;
          end
          if (nctl == 16) begin
            extra_left = v;
            return;
          end
          seek = v;
          nctl = 0;
          room = {32'd0, new_size} - {31'd0, pos};
          if (diff_left[63] || extra_left[63] || diff_left > room ||
              extra_left > room - diff_left) begin
            r.new_byte = 8'd0;
            r.new_index = pos[31:0];
            r.status = 1'b1;
            r.done_flag = 1'b0;
            pending.push_back(r);
            ph = ST_HALT;
          end else if (diff_left != 0) begin
            ph = ST_DIFF;
          end else if (extra_left != 0) begin
            ph = ST_EXTRA;
          end else begin
            close_group();
          end
        end
        ST_DIFF: begin
          val = b;
          if (opos < old_limit()) val = b + img[opos[15:0]];
          opos = opos + 64'd1;
          emit(val);
          diff_left = diff_left - 64'd1;
          if (diff_left == 0) begin
            if (extra_left != 0) ph = ST_EXTRA;
            else close_group();
          end
        end
        ST_EXTRA: begin
          emit(b);
          extra_left = extra_left - 64'd1;
          if (extra_left == 0) close_group();
        end
        default: ;
      endcase
    endfunction

    function void check(logic [7:0] nb, logic [31:0] ix, logic st, logic dn);
      patch_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: new_byte %0h new_index %0h status %0b", nb, ix, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (nb !== e.new_byte) begin
        $error("new_byte expected %0h got %0h", e.new_byte, nb);
        errors++;
      end
      if (ix !== e.new_index) begin
        $error("new_index expected %0h got %0h", e.new_index, ix);
        errors++;
      end
      if (st !== e.status) begin
        $error("status expected %0b got %0b", e.status, st);
        errors++;
      end
      if (dn !== e.done_flag) begin
        $error("last expected %0b got %0b", e.done_flag, dn);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // old_addr[15:0], data_byte[23:16]
  logic        s_axis_tuser = bdp_pkg::MODE_LOAD;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // new_byte[7:0], new_index[39:8]
  logic        m_axis_tuser;  // status
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = bdp_pkg::CFG_OLD_SIZE;
  logic [31:0] cfg_data = '0;

  patch_book book = new();
  int burst_left = 0;
  int n_items = 0;
  bit want_last = 1'b0;
  int sink_style = 0;
  int sink_left = 0;
  int sink_cnt = 0;

  binary_delta_patch_apply uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // receiver stall pattern
  always @(posedge clk) begin
    sink_cnt <= sink_cnt + 1;
    if (sink_left == 0) begin
      sink_style <= $urandom_range(0, 3);
      sink_left <= $urandom_range(20, 120);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (sink_cnt[1:0] != 2'd0);
    endcase
  end

  // outputs are stable mid-cycle; a transaction completes at the next edge
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready)
      book.check(m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tuser, m_axis_tlast);
  end

  initial begin
    #4000000;
    $display("binary_delta_patch_apply_test: errors");
    $finish;
  end

  task automatic push(logic m, logic [15:0] a, logic [7:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {b, a};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    book.note(m, a, b);
    n_items++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (book.pending.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    book.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stray image writes, and a load ahead of any diff byte that would read
  // an entry never written
  task automatic push_patch(logic [7:0] b);
    logic [15:0] a;
    if ($urandom_range(0, 9) == 0) push(bdp_pkg::MODE_LOAD, 16'($urandom), 8'($urandom));
    if (book.unloaded(a)) push(bdp_pkg::MODE_LOAD, a, 8'($urandom));
    push(bdp_pkg::MODE_PATCH, 16'($urandom), b);
  endtask

  task automatic send_word(logic [63:0] w);
    int i;
    for (i = 0; i < 8; i++) push_patch(w[8*i +: 8]);
  endtask

  function automatic logic [63:0] to_sm(logic [63:0] v);
    logic [63:0] mag;
    if (!v[63]) return v;
    mag = -v;
    return {1'b1, mag[62:0]};
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 0;
    if (r < 18) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  // split >= 0: new_size is pulled in mid-group so that last shows and the
  // position overshoots it, then restored before the group ends
  task automatic send_group(logic [63:0] dw, logic [63:0] ew, logic [63:0] sw,
                            int nbytes, int split);
    int i;
    logic [31:0] keep;
    send_word(dw);
    send_word(ew);
    send_word(sw);
    keep = book.new_size;
    for (i = 0; i < nbytes; i++) begin
      if (split >= 0 && i == split) begin
        drain();
        cfg_write(bdp_pkg::CFG_NEW_SIZE, book.pos[31:0] + 32'd2);
      end
      if (split >= 0 && i == split + 3) begin
        drain();
        cfg_write(bdp_pkg::CFG_NEW_SIZE, keep);
      end
      push_patch(8'($urandom));
    end
  endtask

  task automatic random_group();
    int nd;
    int ne;
    int split;
    logic [63:0] dw;
    logic [63:0] ew;
    logic [63:0] sw;
    logic [63:0] tgt;
    nd = pick_len();
    ne = pick_len();
    if (want_last) begin
      nd = $urandom_range(4, 8);
      ne = $urandom_range(2, 4);
    end
    dw = 64'(nd);
    ew = 64'(ne);
    if (nd == 0 && $urandom_range(0, 2) == 0) dw = MINUS_ZERO;
    if (ne == 0 && $urandom_range(0, 2) == 0) ew = MINUS_ZERO;
    split = -1;
    if (want_last || (nd + ne >= 6 && $urandom_range(0, 15) == 0))
      split = $urandom_range(0, nd + ne - 4);
    want_last = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        tgt = 64'($urandom_range(0, 32'(book.old_limit()) + 8));
        sw = to_sm(tgt - book.opos - 64'(nd));
      end
      6, 7: sw = {1'($urandom), 55'd0, 8'($urandom_range(0, 6))};
      8: sw = {$urandom, $urandom};
      default: sw = $urandom_range(0, 1) ? MINUS_ZERO : 64'd0;
    endcase
    send_group(dw, ew, sw, nd + ne, split);
  endtask

  task automatic run_phase(logic [31:0] osz, logic [31:0] nsz, int quota);
    int stop;
    drain();
    cfg_write(bdp_pkg::CFG_OLD_SIZE, osz);
    cfg_write(bdp_pkg::CFG_NEW_SIZE, nsz);
    want_last = 1'b1;
    stop = n_items + quota;
    while (n_items < stop) begin
      random_group();
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // terminal case: one of the corrupt group checks, or the image completes
  task automatic finish_stream();
    int i;
    logic [31:0] base;
    drain();
    base = book.pos[31:0];
    case ($urandom_range(0, 5))
      0: send_group({1'b1, 63'd3}, 64'd1, 64'd0, 0, -1);
      1: send_group(64'd2, {1'b1, 63'd1}, 64'd0, 0, -1);
      2: begin
        cfg_write(bdp_pkg::CFG_NEW_SIZE, base + 32'd5);
        send_group(64'd6, 64'd0, 64'd0, 0, -1);
      end
      3: begin
        cfg_write(bdp_pkg::CFG_NEW_SIZE, base + 32'd5);
        send_group(64'd3, 64'd3, 64'd0, 0, -1);
      end
      4: begin
        cfg_write(bdp_pkg::CFG_NEW_SIZE, base + 32'd5);
        send_group(64'd2, 64'd3, 64'd0, 5, -1);
      end
      default: begin
        cfg_write(bdp_pkg::CFG_NEW_SIZE,
                  $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, base));
      end
    endcase
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 3) == 0) push(bdp_pkg::MODE_LOAD, 16'($urandom), 8'($urandom));
      else push(bdp_pkg::MODE_PATCH, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    cfg_write(bdp_pkg::CFG_NEW_SIZE, 32'hFFFF_FFFF);
    cfg_write(bdp_pkg::CFG_OLD_SIZE, 32'd4);
    push(bdp_pkg::MODE_LOAD, 16'h0000, 8'hFF);
    push(bdp_pkg::MODE_LOAD, 16'h0001, 8'h00);
    push(bdp_pkg::MODE_LOAD, 16'h0002, 8'h80);
    push(bdp_pkg::MODE_LOAD, 16'h0003, 8'h7F);
    push(bdp_pkg::MODE_LOAD, 16'hFFFF, 8'hAA);
    push(bdp_pkg::MODE_LOAD, 16'h5555, 8'h55);
    // diff over the whole image, empty group seeking back, diff past the end
    send_group(64'd4, 64'd2, MINUS_ZERO, 6, -1);
    send_group(MINUS_ZERO, MINUS_ZERO, to_sm(-64'd4), 0, -1);
    send_group(64'd5, 64'd1, to_sm(-64'd5), 6, -1);

    run_phase(32'd0, 32'hFFFF_FFFF, 330);
    run_phase(32'd65536, $urandom_range(book.pos[31:0] + 50000, 32'hFFFF_FFFF), 330);
    run_phase(32'd1, 32'hFFFF_FFFF, 330);
    run_phase($urandom_range(2, 700), 32'hFFFF_FFFF, 330);
    run_phase($urandom_range(1, 65536),
              $urandom_range(book.pos[31:0] + 50000, 32'hFFFF_FFFF), 330);
    finish_stream();
    drain();

    if (book.errors == 0) begin
      $display("binary_delta_patch_apply_test: clean");
    end else begin
      $display("binary_delta_patch_apply_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bdp_pkg.sv
rtl/bdp_ctrl.sv
rtl/binary_delta_patch_apply.sv
tb/binary_delta_patch_apply_test.sv
